[src/rtcep_pkg.sv]
`timescale 1ns / 1ps
// rtcep_pkg: shared types, constants and the month table for the rtc to epoch converter
// no dependencies; used by every module under src

package rtcep_pkg;

    // configuration register indexes
    localparam logic [0:0] REG_HAS_CENTURY = 1'd0;
    localparam logic [0:0] REG_PIVOT_YEAR  = 1'd1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [11:0] PIVOT_RESET      = 12'd2014;
    localparam logic [11:0] PIVOT_BASE_RESET = 12'd2000;

    // status byte b and hour byte masks
    localparam logic [7:0] STB_BINARY_MASK = 8'h04;
    localparam logic [7:0] STB_24H_MASK    = 8'h02;
    localparam logic [7:0] HOUR_PM_MASK    = 8'h80;

    localparam logic [14:0] EPOCH_YEAR          = 15'd1970;
    localparam logic [8:0]  LEAPS_BEFORE_EPOCH  = 9'd477;
    localparam logic [16:0] SECS_PER_DAY        = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR       = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN        = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR       = 9'd365;
    localparam logic [6:0]  YEARS_PER_CENTURY   = 7'd100;
    localparam logic [4:0]  HOURS_PER_DAY       = 5'd24;
    localparam logic [4:0]  PM_OFFSET           = 5'd12;

    // reciprocal multipliers for exact division by 100
    localparam logic [12:0] PIVOT_RECIP_100 = 13'd5243;   // 12-bit operand, shift 19
    localparam int          PIVOT_RECIP_SH  = 19;
    localparam logic [14:0] YEAR_RECIP_100  = 15'd20972;  // 15-bit operand, shift 21
    localparam int          YEAR_RECIP_SH   = 21;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic [7:0] status_b;
    } raw_t;

    typedef struct packed {
        logic        has_century;
        logic [11:0] pivot_year;
        logic [11:0] pivot_base;   // pivot rounded down to a whole century
    } cfg_t;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [14:0] full_year;
    } dec_t;

    typedef struct packed {
        dec_t        dec;
        logic        range_error;
        logic [23:0] days_p1;      // days since epoch plus one
        logic [19:0] time_of_day;  // hour, minute, second in seconds
    } days_t;

    // cumulative days before each month, index is month minus one
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[src/rtcep_decode.sv]
`timescale 1ns / 1ps
// rtcep_decode: first pipeline stage, bcd decode, 12/24-hour fold and full year
// depends on rtcep_pkg

module rtcep_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  rtcep_pkg::cfg_t  cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtcep_pkg::raw_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rtcep_pkg::dec_t  out_data
);

    function automatic logic [7:0] bcd8(input logic [7:0] v);
        return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
    endfunction

    logic             valid_reg;
    rtcep_pkg::dec_t  data_reg;
    rtcep_pkg::dec_t  data_next;

    logic [7:0]  year2;
    logic [7:0]  cent;
    logic [7:0]  hr;
    logic [7:0]  pm_hr;
    logic [12:0] piv_year;

    always_comb begin
        data_next = data_reg;
        if ((in_data.status_b & rtcep_pkg::STB_BINARY_MASK) == 8'd0) begin
            data_next.second = bcd8(in_data.second);
            data_next.minute = bcd8(in_data.minute);
            data_next.day    = bcd8(in_data.day);
            data_next.month  = bcd8(in_data.month);
            year2            = bcd8(in_data.year);
            cent             = bcd8(in_data.century);
            // hour tens digit is bits 6..4, pm flag kept in bit 7
            hr = {in_data.hour[7],
                  7'(in_data.hour[3:0]) + 7'(in_data.hour[6:4]) * 7'd10};
        end else begin
            data_next.second = in_data.second;
            data_next.minute = in_data.minute;
            data_next.day    = in_data.day;
            data_next.month  = in_data.month;
            year2            = in_data.year;
            cent             = in_data.century;
            hr               = in_data.hour;
        end

        // pm fold: (h + 12) mod 24, value below 140
        pm_hr = 8'(hr[6:0]) + 8'(rtcep_pkg::PM_OFFSET);
        if (pm_hr >= 8'(rtcep_pkg::HOURS_PER_DAY) * 8'd4) begin
            pm_hr = pm_hr - 8'(rtcep_pkg::HOURS_PER_DAY) * 8'd4;
        end
        if (pm_hr >= 8'(rtcep_pkg::HOURS_PER_DAY) * 8'd2) begin
            pm_hr = pm_hr - 8'(rtcep_pkg::HOURS_PER_DAY) * 8'd2;
        end
        if (pm_hr >= 8'(rtcep_pkg::HOURS_PER_DAY)) begin
            pm_hr = pm_hr - 8'(rtcep_pkg::HOURS_PER_DAY);
        end
        if ((in_data.status_b & rtcep_pkg::STB_24H_MASK) == 8'd0 &&
            (hr & rtcep_pkg::HOUR_PM_MASK) != 8'd0) begin
            data_next.hour = pm_hr;
        end else begin
            data_next.hour = hr;
        end

        piv_year = 13'(cfg.pivot_base) + 13'(year2);
        if (piv_year < 13'(cfg.pivot_year)) begin
            piv_year = piv_year + 13'(rtcep_pkg::YEARS_PER_CENTURY);
        end
        if (cfg.has_century) begin
            data_next.full_year = 15'(year2)
                                + 15'(cent) * 15'(rtcep_pkg::YEARS_PER_CENTURY);
        end else begin
            data_next.full_year = 15'(piv_year);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[src/rtcep_days.sv]
`timescale 1ns / 1ps
// rtcep_days: three pipeline stages counting days since the epoch with leap days
// depends on rtcep_pkg

module rtcep_days (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtcep_pkg::dec_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rtcep_pkg::days_t out_data
);

    typedef struct packed {
        rtcep_pkg::dec_t dec;
        logic            range_error;
        logic [8:0]      cent_q;       // year / 100
        logic [14:0]     years_since;  // year - 1970
        logic [8:0]      month_days;
        logic [19:0]     time_of_day;
    } sta_t;

    typedef struct packed {
        rtcep_pkg::dec_t dec;
        logic            range_error;
        logic [8:0]      cent_q;
        logic            cent_exact;   // year is a multiple of 100
        logic [23:0]     year_days;
        logic [12:0]     quads;        // (year - 1) / 4
        logic [8:0]      month_days;
        logic [19:0]     time_of_day;
    } stb_t;

    logic  va_reg, vb_reg, vc_reg;
    logic  rdy_a, rdy_b, rdy_c;
    sta_t  sta_reg, sta_next;
    stb_t  stb_reg, stb_next;
    rtcep_pkg::days_t stc_reg, stc_next;

    logic [29:0] q_prod;
    logic [8:0]  cent_p;   // (year - 1) / 100
    logic        leap;

    // stage a: range check, year / 100, month offset, time of day
    always_comb begin
        q_prod = 30'(in_data.full_year) * 30'(rtcep_pkg::YEAR_RECIP_100);
        sta_next.dec = in_data;
        sta_next.range_error = (in_data.month == 8'd0) || (in_data.month > 8'd12) ||
                               (in_data.full_year < rtcep_pkg::EPOCH_YEAR);
        sta_next.cent_q      = q_prod[rtcep_pkg::YEAR_RECIP_SH +: 9];
        sta_next.years_since = in_data.full_year - rtcep_pkg::EPOCH_YEAR;
        sta_next.month_days  = rtcep_pkg::cum_days(in_data.month[3:0] - 4'd1);
        sta_next.time_of_day = 20'(in_data.hour) * 20'(rtcep_pkg::SECS_PER_HOUR)
                             + 20'(in_data.minute) * 20'(rtcep_pkg::SECS_PER_MIN)
                             + 20'(in_data.second);
    end

    // stage b: days in whole years, (year - 1) / 4, century test
    always_comb begin
        stb_next.dec         = sta_reg.dec;
        stb_next.range_error = sta_reg.range_error;
        stb_next.cent_q      = sta_reg.cent_q;
        stb_next.cent_exact  = sta_reg.dec.full_year ==
                               15'(15'(sta_reg.cent_q) * 15'(rtcep_pkg::YEARS_PER_CENTURY));
        stb_next.year_days   = 24'(sta_reg.years_since) * 24'(rtcep_pkg::DAYS_PER_YEAR);
        stb_next.quads       = 13'((sta_reg.dec.full_year - 15'd1) >> 2);
        stb_next.month_days  = sta_reg.month_days;
        stb_next.time_of_day = sta_reg.time_of_day;
    end

    // stage c: leap days before the year, leap day of this year, day of month
    always_comb begin
        cent_p = stb_reg.cent_q - 9'(stb_reg.cent_exact);
        if (stb_reg.cent_exact) begin
            leap = stb_reg.cent_q[1:0] == 2'd0;
        end else begin
            leap = stb_reg.dec.full_year[1:0] == 2'd0;
        end
        stc_next.dec         = stb_reg.dec;
        stc_next.range_error = stb_reg.range_error;
        stc_next.time_of_day = stb_reg.time_of_day;
        stc_next.days_p1     = 24'(25'(stb_reg.year_days) + 25'(stb_reg.quads)
                             - 25'(cent_p) + 25'(cent_p >> 2)
                             - 25'(rtcep_pkg::LEAPS_BEFORE_EPOCH)
                             + 25'(stb_reg.month_days)
                             + 25'(leap && (stb_reg.dec.month > 8'd2))
                             + 25'(stb_reg.dec.day));
    end

    assign rdy_c     = !vc_reg || out_ready;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign in_ready  = rdy_a;
    assign out_valid = vc_reg;
    assign out_data  = stc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
            if (rdy_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            sta_reg <= sta_next;
        end
        if (rdy_b && va_reg) begin
            stb_reg <= stb_next;
        end
        if (rdy_c && vb_reg) begin
            stc_reg <= stc_next;
        end
    end

endmodule

[src/rtcep_secs.sv]
`timescale 1ns / 1ps
// rtcep_secs: two pipeline stages, day count to seconds, clamp and saturate
// depends on rtcep_pkg; its last stage is the block's output register

module rtcep_secs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtcep_pkg::days_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [32:0]      out_epoch,
    output rtcep_pkg::dec_t  out_dec,
    output logic             out_error
);

    typedef struct packed {
        rtcep_pkg::dec_t dec;
        logic            range_error;
        logic [41:0]     total_p1;     // seconds plus one day
    } std_t;

    typedef struct packed {
        rtcep_pkg::dec_t dec;
        logic            range_error;
        logic [32:0]     epoch;
    } ste_t;

    logic  vd_reg, ve_reg;
    logic  rdy_d, rdy_e;
    std_t  std_reg, std_next;
    ste_t  ste_reg, ste_next;
    logic [41:0] diff;

    always_comb begin
        std_next.dec         = in_data.dec;
        std_next.range_error = in_data.range_error;
        std_next.total_p1    = 42'(in_data.days_p1) * 42'(rtcep_pkg::SECS_PER_DAY)
                             + 42'(in_data.time_of_day);
    end

    always_comb begin
        diff = std_reg.total_p1 - 42'(rtcep_pkg::SECS_PER_DAY);
        ste_next.dec         = std_reg.dec;
        ste_next.range_error = std_reg.range_error;
        if (std_reg.range_error ||
            std_reg.total_p1 < 42'(rtcep_pkg::SECS_PER_DAY)) begin
            ste_next.epoch = '0;
        end else if (diff[41:33] != 9'd0) begin
            ste_next.epoch = '1;
        end else begin
            ste_next.epoch = diff[32:0];
        end
    end

    assign rdy_e     = !ve_reg || out_ready;
    assign rdy_d     = !vd_reg || rdy_e;
    assign in_ready  = rdy_d;
    assign out_valid = ve_reg;
    assign out_epoch = ste_reg.epoch;
    assign out_dec   = ste_reg.dec;
    assign out_error = ste_reg.range_error;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (rdy_d) begin
                vd_reg <= in_valid;
            end
            if (rdy_e) begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_d && in_valid) begin
            std_reg <= std_next;
        end
        if (rdy_e && vd_reg) begin
            ste_reg <= ste_next;
        end
    end

endmodule

[src/rtc_fields_to_epoch_seconds.sv]
`timescale 1ns / 1ps
// rtc_fields_to_epoch_seconds: top level, configuration registers and the six-stage pipeline
// depends on rtcep_pkg, rtcep_decode, rtcep_days, rtcep_secs
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata[63:0]  raw rtc snapshot
//  m_        out        m_tvalid/m_tready  m_tdata[87:0]  decoded fields, m_tuser[0] error
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata[11:0]
//
//  one transfer per cycle sustained while m_tready is held high; one register per stage
//  (decode, range/century, year days, leap days, seconds multiply, clamp/output)
//  each stage holds its own valid bit and takes new data whenever its successor
//  frees, so bubbles close up under an output stall and nothing is lost or repeated
//  synchronous active-low reset clears valid bits and the configuration registers

module rtc_fields_to_epoch_seconds (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rtcep_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rtcep_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // input snapshot
    input  logic        s_tvalid,
    output logic        s_tready,
    // lsb up: raw_second, raw_minute, raw_hour, raw_day, raw_month,
    //         raw_year, raw_century, status_b (8 bits each)
    input  logic [63:0] s_tdata,

    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    // lsb up: epoch_seconds[33], out_second[8], out_minute[8], out_hour[8],
    //         out_day[8], out_month[8], full_year[15]
    output logic [87:0] m_tdata,
    // lsb up: range_error
    output logic [0:0]  m_tuser
);

    rtcep_pkg::cfg_t    cfg_reg;
    rtcep_pkg::raw_t    raw;
    rtcep_pkg::dec_t    dec_data;
    rtcep_pkg::days_t   days_data;
    rtcep_pkg::dec_t    out_dec;

    logic        dec_valid, dec_ready;
    logic        days_valid, days_ready;
    logic [32:0] out_epoch;
    logic        out_error;

    // pivot century base: pivot / 100 * 100 through a reciprocal multiply
    logic [24:0] piv_prod;
    logic [5:0]  piv_cent;

    assign piv_prod = 25'(cfg_wdata) * 25'(rtcep_pkg::PIVOT_RECIP_100);
    assign piv_cent = piv_prod[rtcep_pkg::PIVOT_RECIP_SH +: 6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.has_century <= 1'b0;
            cfg_reg.pivot_year  <= rtcep_pkg::PIVOT_RESET;
            cfg_reg.pivot_base  <= rtcep_pkg::PIVOT_BASE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rtcep_pkg::REG_HAS_CENTURY: begin
                    cfg_reg.has_century <= cfg_wdata[0];
                end
                rtcep_pkg::REG_PIVOT_YEAR: begin
                    cfg_reg.pivot_year <= cfg_wdata;
                    cfg_reg.pivot_base <= 12'(13'(piv_cent)
                                        * 13'(rtcep_pkg::YEARS_PER_CENTURY));
                end
                default: begin
                end
            endcase
        end
    end

    // unpack the snapshot, lowest field first
    assign raw.second   = s_tdata[7:0];
    assign raw.minute   = s_tdata[15:8];
    assign raw.hour     = s_tdata[23:16];
    assign raw.day      = s_tdata[31:24];
    assign raw.month    = s_tdata[39:32];
    assign raw.year     = s_tdata[47:40];
    assign raw.century  = s_tdata[55:48];
    assign raw.status_b = s_tdata[63:56];

    // stage 1
    rtcep_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (raw),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // stages 2 to 4
    rtcep_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_data  (days_data)
    );

    // stages 5 and 6, the last one drives the result channel
    rtcep_secs u_secs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (days_valid),
        .in_ready  (days_ready),
        .in_data   (days_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_epoch (out_epoch),
        .out_dec   (out_dec),
        .out_error (out_error)
    );

    assign m_tdata = {out_dec.full_year, out_dec.month, out_dec.day, out_dec.hour,
                      out_dec.minute, out_dec.second, out_epoch};
    assign m_tuser = out_error;

endmodule
